// ===== rtl/sct_pkg.sv =====
// sct_pkg: shared types, codes and character constants for the source code tokenizer.
// No dependencies; used by every module of the block.

package sct_pkg;

    localparam int LINE_BITS_DEF = 24;
    localparam int OUT_LINE_BITS = 24;
    localparam logic [OUT_LINE_BITS-1:0] OUT_LINE_MAX = '1;
    localparam int QUEUE_DEPTH = 4;
    localparam logic [3:0] MAX_CHAR_LEN_RST = 4'd2;

    // token kinds
    localparam logic [4:0] KIND_ID       = 5'd0;
    localparam logic [4:0] KIND_INT      = 5'd1;
    localparam logic [4:0] KIND_FLOAT    = 5'd2;
    localparam logic [4:0] KIND_STR      = 5'd3;
    localparam logic [4:0] KIND_CHR      = 5'd4;
    localparam logic [4:0] KIND_PLUS     = 5'd5;
    localparam logic [4:0] KIND_PLUS_EQ  = 5'd6;
    localparam logic [4:0] KIND_MINUS    = 5'd7;
    localparam logic [4:0] KIND_MINUS_EQ = 5'd8;
    localparam logic [4:0] KIND_STAR     = 5'd9;
    localparam logic [4:0] KIND_STAR_EQ  = 5'd10;
    localparam logic [4:0] KIND_AND_AND  = 5'd11;
    localparam logic [4:0] KIND_ASSIGN   = 5'd12;
    localparam logic [4:0] KIND_EQ_EQ    = 5'd13;
    localparam logic [4:0] KIND_BANG     = 5'd14;
    localparam logic [4:0] KIND_NOT_EQ   = 5'd15;
    localparam logic [4:0] KIND_LBRACE   = 5'd16;
    localparam logic [4:0] KIND_RBRACE   = 5'd17;
    localparam logic [4:0] KIND_LBRACK   = 5'd18;
    localparam logic [4:0] KIND_RBRACK   = 5'd19;
    localparam logic [4:0] KIND_LPAREN   = 5'd20;
    localparam logic [4:0] KIND_RPAREN   = 5'd21;
    localparam logic [4:0] KIND_SEMI     = 5'd22;
    localparam logic [4:0] KIND_COMMA    = 5'd23;
    localparam logic [4:0] KIND_SLASH    = 5'd24;
    localparam logic [4:0] KIND_PERCENT  = 5'd25;
    localparam logic [4:0] KIND_DOT      = 5'd26;
    localparam logic [4:0] KIND_LT       = 5'd27;
    localparam logic [4:0] KIND_GT       = 5'd28;
    localparam logic [4:0] KIND_EOF      = 5'd29;

    // error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
    localparam logic [1:0] ERR_CHAR_LONG  = 2'd2;

    // characters
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_BANG       = 8'h21;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_AMP        = 8'h26;
    localparam logic [7:0] CH_SQUOTE     = 8'h27;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_EQ         = 8'h3D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    typedef enum logic [2:0] {
        LEX_IDLE,
        LEX_ID,
        LEX_INT,
        LEX_FLOAT,
        LEX_STR,
        LEX_CHR,
        LEX_OP,
        LEX_ERR
    } lex_mode_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PLUS,
        OP_MINUS,
        OP_STAR,
        OP_AMP,
        OP_EQ,
        OP_BANG
    } op_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [4:0]               token_kind;
        logic [7:0]               value_byte;
        logic                     has_byte;
        logic                     token_first;
        logic                     token_last;
        logic [1:0]               error_code;
        logic [OUT_LINE_BITS-1:0] line_number;
        logic                     run_last;
    } out_item_t;

    // what one input transaction produces: one or two results
    typedef struct packed {
        out_item_t res_a;
        out_item_t res_b;
        logic      has_b;
    } bundle_t;

    function automatic out_item_t make_result(input logic [4:0] kind,
                                              input logic [7:0] b,
                                              input logic has,
                                              input logic first,
                                              input logic last,
                                              input logic [1:0] err,
                                              input logic [OUT_LINE_BITS-1:0] line);
        out_item_t r;
        r.token_kind  = kind;
        r.value_byte  = has ? b : 8'd0;
        r.has_byte    = has;
        r.token_first = first;
        r.token_last  = last;
        r.error_code  = err;
        r.line_number = line;
        r.run_last    = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/sct_front.sv =====
// sct_front: accepts source bytes, tracks lexer state and builds the result bundle.
// Depends on sct_pkg.

module sct_front #(
    parameter int LINE_BITS = sct_pkg::LINE_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic [3:0]        cfg_data,
    input  logic              s_valid,
    input  sct_pkg::in_item_t s_data,
    input  logic              q_full,
    output logic              push,
    output sct_pkg::bundle_t  push_data
);

    localparam int LINE_EXT = (LINE_BITS > sct_pkg::OUT_LINE_BITS) ? LINE_BITS
                                                                   : sct_pkg::OUT_LINE_BITS;

    typedef struct packed {
        logic               emit;
        logic [4:0]         kind;
        logic               has;
        logic               last;
        logic [1:0]         err;
        sct_pkg::lex_mode_t mode;
        sct_pkg::op_t       op;
        logic               clr_cnt;
        logic               newline;
    } start_t;

    sct_pkg::lex_mode_t   mode_reg, mode_next;
    sct_pkg::op_t         op_reg, op_next;
    logic [3:0]           cnt_reg, cnt_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [3:0]           max_len_reg;

    logic                 accept;
    logic [7:0]           b;
    logic [LINE_EXT-1:0]  line_wide;
    logic [sct_pkg::OUT_LINE_BITS-1:0] line_out;
    start_t               st;
    logic                 inc_line;
    logic                 n_two;
    logic                 n_any;
    logic                 is_dig, is_alp;
    sct_pkg::out_item_t   ra, rb, close_r;
    logic                 close_ok;

    function automatic logic [4:0] op_single(input sct_pkg::op_t o);
        case (o)
            sct_pkg::OP_MINUS: return sct_pkg::KIND_MINUS;
            sct_pkg::OP_STAR:  return sct_pkg::KIND_STAR;
            sct_pkg::OP_AMP:   return sct_pkg::KIND_AND_AND;
            sct_pkg::OP_EQ:    return sct_pkg::KIND_ASSIGN;
            sct_pkg::OP_BANG:  return sct_pkg::KIND_BANG;
            default:           return sct_pkg::KIND_PLUS;
        endcase
    endfunction

    function automatic logic [4:0] op_double(input sct_pkg::op_t o);
        case (o)
            sct_pkg::OP_MINUS: return sct_pkg::KIND_MINUS_EQ;
            sct_pkg::OP_STAR:  return sct_pkg::KIND_STAR_EQ;
            sct_pkg::OP_AMP:   return sct_pkg::KIND_AND_AND;
            sct_pkg::OP_EQ:    return sct_pkg::KIND_EQ_EQ;
            sct_pkg::OP_BANG:  return sct_pkg::KIND_NOT_EQ;
            default:           return sct_pkg::KIND_PLUS_EQ;
        endcase
    endfunction

    function automatic start_t classify(input logic [7:0] c);
        start_t s;
        s.emit    = 1'b1;
        s.kind    = sct_pkg::KIND_ID;
        s.has     = 1'b1;
        s.last    = 1'b0;
        s.err     = sct_pkg::ERR_NONE;
        s.mode    = sct_pkg::LEX_IDLE;
        s.op      = sct_pkg::OP_NONE;
        s.clr_cnt = 1'b0;
        s.newline = 1'b0;
        if (c == sct_pkg::CH_SPACE || c == sct_pkg::CH_CR || c == sct_pkg::CH_LF) begin
            s.emit    = 1'b0;
            s.newline = (c == sct_pkg::CH_LF);
        end else if (c >= "0" && c <= "9") begin
            s.kind = sct_pkg::KIND_INT;
            s.mode = sct_pkg::LEX_INT;
        end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
            s.mode = sct_pkg::LEX_ID;
        end else begin
            case (c)
                sct_pkg::CH_PLUS:  s.op = sct_pkg::OP_PLUS;
                sct_pkg::CH_MINUS: s.op = sct_pkg::OP_MINUS;
                sct_pkg::CH_STAR:  s.op = sct_pkg::OP_STAR;
                sct_pkg::CH_AMP:   s.op = sct_pkg::OP_AMP;
                sct_pkg::CH_EQ:    s.op = sct_pkg::OP_EQ;
                sct_pkg::CH_BANG:  s.op = sct_pkg::OP_BANG;
                default:           s.op = sct_pkg::OP_NONE;
            endcase
            if (s.op != sct_pkg::OP_NONE) begin
                s.kind = op_single(s.op);
                s.mode = sct_pkg::LEX_OP;
            end else if (c == sct_pkg::CH_DQUOTE) begin
                s.kind = sct_pkg::KIND_STR;
                s.has  = 1'b0;
                s.mode = sct_pkg::LEX_STR;
            end else if (c == sct_pkg::CH_SQUOTE) begin
                s.kind    = sct_pkg::KIND_CHR;
                s.has     = 1'b0;
                s.mode    = sct_pkg::LEX_CHR;
                s.clr_cnt = 1'b1;
            end else begin
                s.last = 1'b1;
                case (c)
                    "{":     s.kind = sct_pkg::KIND_LBRACE;
                    "}":     s.kind = sct_pkg::KIND_RBRACE;
                    "[":     s.kind = sct_pkg::KIND_LBRACK;
                    "]":     s.kind = sct_pkg::KIND_RBRACK;
                    "(":     s.kind = sct_pkg::KIND_LPAREN;
                    ")":     s.kind = sct_pkg::KIND_RPAREN;
                    ";":     s.kind = sct_pkg::KIND_SEMI;
                    ",":     s.kind = sct_pkg::KIND_COMMA;
                    "/":     s.kind = sct_pkg::KIND_SLASH;
                    "%":     s.kind = sct_pkg::KIND_PERCENT;
                    ".":     s.kind = sct_pkg::KIND_DOT;
                    "<":     s.kind = sct_pkg::KIND_LT;
                    ">":     s.kind = sct_pkg::KIND_GT;
                    default: begin
                        s.kind = sct_pkg::KIND_ID;
                        s.err  = sct_pkg::ERR_UNEXPECTED;
                        s.mode = sct_pkg::LEX_ERR;
                    end
                endcase
            end
        end
        return s;
    endfunction

    assign accept = s_valid && !q_full;
    assign b      = s_data.in_byte;
    assign is_dig = (b >= "0" && b <= "9");
    assign is_alp = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");

    // all results of one transaction carry the line count from before it
    assign line_wide = LINE_EXT'(line_reg);
    assign line_out  = (line_wide > LINE_EXT'(sct_pkg::OUT_LINE_MAX)) ? sct_pkg::OUT_LINE_MAX
                                                  : line_wide[sct_pkg::OUT_LINE_BITS-1:0];
    assign st = classify(b);

    // closing result for an open token, used on end of input and on token breaks
    always_comb begin
        close_ok = 1'b1;
        close_r  = sct_pkg::make_result(sct_pkg::KIND_ID, 8'd0, 1'b0, 1'b0, 1'b1,
                                        sct_pkg::ERR_NONE, line_out);
        case (mode_reg)
            sct_pkg::LEX_ID:    close_r.token_kind = sct_pkg::KIND_ID;
            sct_pkg::LEX_INT:   close_r.token_kind = sct_pkg::KIND_INT;
            sct_pkg::LEX_FLOAT: close_r.token_kind = sct_pkg::KIND_FLOAT;
            sct_pkg::LEX_STR:   close_r.token_kind = sct_pkg::KIND_STR;
            sct_pkg::LEX_CHR:   close_r.token_kind = sct_pkg::KIND_CHR;
            sct_pkg::LEX_OP: begin
                if (op_reg == sct_pkg::OP_AMP) begin
                    close_r.error_code = sct_pkg::ERR_UNEXPECTED;
                end else begin
                    close_r.token_kind = op_single(op_reg);
                end
            end
            default: close_ok = 1'b0;
        endcase
    end

    always_comb begin
        mode_next = mode_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        inc_line  = 1'b0;
        n_any     = 1'b0;
        n_two     = 1'b0;
        ra        = close_r;
        rb        = sct_pkg::make_result(st.kind, b, st.has, 1'b1, st.last, st.err, line_out);

        if (s_data.end_of_input) begin
            n_any = 1'b1;
            n_two = close_ok;
            rb    = sct_pkg::make_result(sct_pkg::KIND_EOF, 8'd0, 1'b0, 1'b1, 1'b1,
                                         sct_pkg::ERR_NONE, line_out);
            if (!close_ok) begin
                ra = rb;
            end
            mode_next = sct_pkg::LEX_IDLE;
            op_next   = sct_pkg::OP_NONE;
            cnt_next  = 4'd0;
        end else begin
            case (mode_reg)
                sct_pkg::LEX_ERR: begin
                end
                sct_pkg::LEX_ID, sct_pkg::LEX_INT, sct_pkg::LEX_FLOAT: begin
                    n_any = 1'b1;
                    if (is_dig || (mode_reg == sct_pkg::LEX_ID &&
                                   (is_alp || b == sct_pkg::CH_UNDERSCORE))) begin
                        ra = sct_pkg::make_result(close_r.token_kind, b, 1'b1, 1'b0, 1'b0,
                                                  sct_pkg::ERR_NONE, line_out);
                    end else if (mode_reg == sct_pkg::LEX_INT && b == sct_pkg::CH_DOT) begin
                        ra = sct_pkg::make_result(sct_pkg::KIND_FLOAT, b, 1'b1, 1'b0, 1'b0,
                                                  sct_pkg::ERR_NONE, line_out);
                        mode_next = sct_pkg::LEX_FLOAT;
                    end else begin
                        n_two     = st.emit;
                        mode_next = st.mode;
                        inc_line  = st.newline;
                        if (st.op != sct_pkg::OP_NONE) op_next = st.op;
                        if (st.clr_cnt) cnt_next = 4'd0;
                    end
                end
                sct_pkg::LEX_STR: begin
                    n_any = 1'b1;
                    if (b == sct_pkg::CH_DQUOTE) begin
                        mode_next = sct_pkg::LEX_IDLE;
                    end else begin
                        ra = sct_pkg::make_result(sct_pkg::KIND_STR, b, 1'b1, 1'b0, 1'b0,
                                                  sct_pkg::ERR_NONE, line_out);
                        inc_line = (b == sct_pkg::CH_LF);
                    end
                end
                sct_pkg::LEX_CHR: begin
                    n_any = 1'b1;
                    if (b == sct_pkg::CH_SQUOTE) begin
                        mode_next = sct_pkg::LEX_IDLE;
                        cnt_next  = 4'd0;
                    end else if (cnt_reg >= max_len_reg) begin
                        ra = sct_pkg::make_result(sct_pkg::KIND_ID, 8'd0, 1'b0, 1'b0, 1'b1,
                                                  sct_pkg::ERR_CHAR_LONG, line_out);
                        mode_next = sct_pkg::LEX_ERR;
                    end else begin
                        ra = sct_pkg::make_result(sct_pkg::KIND_CHR, b, 1'b1, 1'b0, 1'b0,
                                                  sct_pkg::ERR_NONE, line_out);
                        inc_line = (b == sct_pkg::CH_LF);
                        cnt_next = cnt_reg + 4'd1;
                    end
                end
                sct_pkg::LEX_OP: begin
                    n_any   = 1'b1;
                    op_next = sct_pkg::OP_NONE;
                    if ((op_reg == sct_pkg::OP_AMP && b == sct_pkg::CH_AMP) ||
                        (op_reg != sct_pkg::OP_AMP && b == sct_pkg::CH_EQ)) begin
                        ra = sct_pkg::make_result(op_double(op_reg), b, 1'b1, 1'b0, 1'b1,
                                                  sct_pkg::ERR_NONE, line_out);
                        mode_next = sct_pkg::LEX_IDLE;
                    end else if (op_reg == sct_pkg::OP_AMP) begin
                        // lone '&': error closes it and the byte is dropped
                        mode_next = sct_pkg::LEX_ERR;
                    end else begin
                        n_two     = st.emit;
                        mode_next = st.mode;
                        inc_line  = st.newline;
                        if (st.op != sct_pkg::OP_NONE) op_next = st.op;
                        if (st.clr_cnt) cnt_next = 4'd0;
                    end
                end
                default: begin
                    n_any     = st.emit;
                    ra        = rb;
                    mode_next = st.mode;
                    inc_line  = st.newline;
                    if (st.op != sct_pkg::OP_NONE) op_next = st.op;
                    if (st.clr_cnt) cnt_next = 4'd0;
                end
            endcase
        end

        if (n_two) begin
            rb.run_last = 1'b1;
        end else begin
            ra.run_last = 1'b1;
        end

        if (s_data.end_of_input) begin
            line_next = LINE_BITS'(1);
        end else if (inc_line && line_reg != '1) begin
            line_next = line_reg + LINE_BITS'(1);
        end else begin
            line_next = line_reg;
        end
    end

    assign push            = accept && n_any;
    assign push_data.res_a = ra;
    assign push_data.res_b = rb;
    assign push_data.has_b = n_two;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= sct_pkg::LEX_IDLE;
            op_reg      <= sct_pkg::OP_NONE;
            cnt_reg     <= 4'd0;
            line_reg    <= LINE_BITS'(1);
            max_len_reg <= sct_pkg::MAX_CHAR_LEN_RST;
        end else begin
            if (cfg_valid) begin
                max_len_reg <= cfg_data;
            end
            if (accept) begin
                mode_reg <= mode_next;
                op_reg   <= op_next;
                cnt_reg  <= cnt_next;
                line_reg <= line_next;
            end
        end
    end

endmodule

// ===== rtl/sct_queue.sv =====
// sct_queue: small register queue of result bundles between front and back.
// Depends on sct_pkg.

module sct_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  sct_pkg::bundle_t push_data,
    input  logic             pop,
    output sct_pkg::bundle_t pop_data,
    output logic             full,
    output logic             empty
);

    localparam int DEPTH = sct_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    sct_pkg::bundle_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop && !empty) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            case ({push && !full, pop && !empty})
                2'b10:   count_reg <= count_reg + CW'(1);
                2'b01:   count_reg <= count_reg - CW'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== rtl/sct_back.sv =====
// sct_back: drains bundles from the queue and presents results one per cycle while m_ready is not holding the output.
// Depends on sct_pkg.

module sct_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  sct_pkg::bundle_t   q_data,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output sct_pkg::out_item_t m_data
);

    logic               valid_reg;
    sct_pkg::out_item_t out_reg;
    logic               second_pend_reg;
    sct_pkg::out_item_t second_reg;
    logic               slot_free;

    assign slot_free = !valid_reg || m_ready;
    assign pop       = slot_free && !second_pend_reg && !q_empty;
    assign m_valid   = valid_reg;
    assign m_data    = out_reg;

    always_ff @(posedge aclk) begin
        if (slot_free) begin
            if (second_pend_reg) begin
                out_reg <= second_reg;
            end else if (!q_empty) begin
                out_reg    <= q_data.res_a;
                second_reg <= q_data.res_b;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= 1'b0;
            second_pend_reg <= 1'b0;
        end else if (slot_free) begin
            if (second_pend_reg) begin
                valid_reg       <= 1'b1;
                second_pend_reg <= 1'b0;
            end else begin
                valid_reg       <= !q_empty;
                second_pend_reg <= !q_empty && q_data.has_b;
            end
        end
    end

endmodule

// ===== rtl/source_code_tokenizer.sv =====
// source_code_tokenizer: one source byte per cycle in while the queue is not full; token bytes and marks out.
// An accepted byte's results pass through the bundle queue and then the output register before m_data.
// A byte that yields two results presents them on the output one after the other.
// The 4-entry bundle queue lets the front keep taking bytes while the output is stalled.
// Reset (aresetn low, synchronous): lexer idle, line 1, queue and output empty,
// max char literal length back to 2. Depends on sct_pkg, sct_front, sct_queue, sct_back.

module source_code_tokenizer #(
    parameter int LINE_BITS = sct_pkg::LINE_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  sct_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sct_pkg::out_item_t m_data
);

    logic             push, pop, q_full, q_empty;
    sct_pkg::bundle_t push_data, pop_data;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;

    sct_front #(
        .LINE_BITS(LINE_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_data    (s_data),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    sct_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    sct_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_data  (pop_data),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== rtl/sct_checker.sv =====
// sct_checker: port-level checks on the tokenizer result channel, bound to the top.
// Depends on sct_pkg and source_code_tokenizer.

module sct_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input sct_pkg::out_item_t m_data
);

    // a stalled transaction holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // every error result is a closing result of id kind
    a_error_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error_code != sct_pkg::ERR_NONE |->
            m_data.token_last && m_data.token_kind == sct_pkg::KIND_ID)
        else $error("error result is not a closing id-kind result");

    a_eof_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.token_kind == sct_pkg::KIND_EOF |->
            m_data.token_first && m_data.token_last && !m_data.has_byte &&
            m_data.run_last && m_data.line_number != '0)
        else $error("malformed EOF result");

    a_empty_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.has_byte |-> m_data.value_byte == 8'd0)
        else $error("value byte set without has_byte");

endmodule

bind source_code_tokenizer sct_checker u_sct_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
